[rtl/char_lcd_shadow_refresh_unit_assert.svh]
// ============================================================================
// Assertion macros for the character LCD shadow refresh unit
// Short forms for the concurrent checks used by the port checker.
// ============================================================================
`ifndef CHAR_LCD_SHADOW_REFRESH_UNIT_ASSERT_SVH
`define CHAR_LCD_SHADOW_REFRESH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CLSR_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CLSR_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CLSR_ASSERT_NXT_ALWAYS(label, clk, pre, post, msg) \
   label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

[rtl/clsr_pkg.sv]
// ============================================================================
// Shared definitions for the character LCD shadow refresh unit
// Sizes, payload types, internal command codes and frame formatting helpers.
// ============================================================================
`default_nettype none

package clsr_pkg;

   // Buffer geometry.
   localparam int ROWS    = 4;
   localparam int COLUMNS = 20;
   localparam int DEPTH   = ROWS * COLUMNS;
   localparam int ROW_W   = 2;
   localparam int COL_W   = 5;
   localparam int SLOT_W  = 5;
   localparam int ADDR_W  = $clog2(DEPTH);

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Character and frame constants.
   localparam logic [7:0] SPACE_CHAR    = 8'h20;
   localparam logic [7:0] CURSOR_CMD    = 8'h80;
   localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
   localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
   localparam logic [7:0] ENABLE_BIT    = 8'h04;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_PUT_CHAR = 2'd0,
      ACT_CLEAR    = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_FAIL     = 2'd3
   } action_type;

   // Internal command codes carried from the front to the back.
   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_PAD   = 3'd1,
      OP_CLEAR = 3'd2,
      OP_TICK  = 3'd3,
      OP_FAIL  = 3'd4
   } op_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] row;
      logic [7:0] character;
      logic       bus_ready;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte_0;
      logic [7:0] frame_byte_1;
      logic [7:0] frame_byte_2;
      logic [7:0] frame_byte_3;
      logic       is_data;
      logic       pass_end;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0]       value;
   } cmd_type;

   // Linear buffer address of a row and column.
   function automatic logic [ADDR_W-1:0] char_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   // Display RAM offset of the first character of each row.
   function automatic logic [7:0] row_offset(input logic [ROW_W-1:0] row);
      logic [7:0] offset;
      case (row)
         2'd0:    offset = 8'h00;
         2'd1:    offset = 8'h40;
         2'd2:    offset = 8'h14;
         2'd3:    offset = 8'h54;
         default: offset = 8'h00;
      endcase
      return offset;
   endfunction

   // Split one LCD byte into the four expander bytes of a 4-bit transfer.
   function automatic rsp_type make_frame(input logic [7:0] lcd_byte,
                                          input logic       rs,
                                          input logic       backlight,
                                          input logic       last);
      rsp_type    frame;
      logic [7:0] ctrl_off;
      logic [7:0] ctrl_on;
      logic [7:0] low_up;
      ctrl_off = (backlight ? BACKLIGHT_BIT : 8'h00) | {7'd0, rs};
      ctrl_on  = ctrl_off | ENABLE_BIT;
      low_up   = {lcd_byte[3:0], 4'h0};
      frame.frame_byte_0 = (lcd_byte & NIBBLE_MASK) | ctrl_on;
      frame.frame_byte_1 = (lcd_byte & NIBBLE_MASK) | ctrl_off;
      frame.frame_byte_2 = low_up | ctrl_on;
      frame.frame_byte_3 = low_up | ctrl_off;
      frame.is_data      = rs;
      frame.pass_end     = last;
      return frame;
   endfunction

endpackage

`default_nettype wire

[rtl/clsr_front.sv]
// ============================================================================
// Request front end
// Accepts requests, tracks the write column and turns each request into at
// most one internal command for the back end.
// ============================================================================
`default_nettype none

module clsr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire clsr_pkg::req_type req_payload,
   input  wire logic             queue_full,
   output logic                  push,
   output clsr_pkg::cmd_type     push_cmd
);

   logic [clsr_pkg::COL_W-1:0] write_column_ff;
   logic [clsr_pkg::COL_W-1:0] write_column_in;
   logic                       accept;
   logic                       has_cmd;
   logic                       row_ok;

   // A request is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && has_cmd;
   assign row_ok    = {1'b0, req_payload.row} < (clsr_pkg::ROW_W + 1)'(clsr_pkg::ROWS);

   // Classify the request.
   always_comb begin
      has_cmd         = 1'b0;
      write_column_in = write_column_ff;
      push_cmd.op     = clsr_pkg::OP_TICK;
      push_cmd.row    = req_payload.row;
      push_cmd.col    = write_column_ff;
      push_cmd.value  = req_payload.character;
      case (req_payload.action)
         clsr_pkg::ACT_PUT_CHAR: begin
            if (row_ok) begin
               if (req_payload.character == 8'h00) begin
                  // Line end pads the rest of the row with spaces.
                  has_cmd         = 1'b1;
                  push_cmd.op     = clsr_pkg::OP_PAD;
                  push_cmd.value  = clsr_pkg::SPACE_CHAR;
                  write_column_in = '0;
               end else if (write_column_ff < clsr_pkg::COL_W'(clsr_pkg::COLUMNS)) begin
                  has_cmd         = 1'b1;
                  push_cmd.op     = clsr_pkg::OP_WRITE;
                  write_column_in = write_column_ff + clsr_pkg::COL_W'(1);
               end
            end
         end
         clsr_pkg::ACT_CLEAR: begin
            has_cmd        = 1'b1;
            push_cmd.op    = clsr_pkg::OP_CLEAR;
            push_cmd.value = clsr_pkg::SPACE_CHAR;
         end
         clsr_pkg::ACT_TICK: begin
            has_cmd     = req_payload.bus_ready;
            push_cmd.op = clsr_pkg::OP_TICK;
         end
         clsr_pkg::ACT_FAIL: begin
            has_cmd     = 1'b1;
            push_cmd.op = clsr_pkg::OP_FAIL;
         end
         default: begin
            has_cmd = 1'b0;
         end
      endcase
   end

   // Write column register.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_column_ff <= '0;
      end else if (accept) begin
         write_column_ff <= write_column_in;
      end
   end

endmodule

`default_nettype wire

[rtl/clsr_queue.sv]
// ============================================================================
// Command queue
// Short first-in first-out queue that decouples the front from the back.
// ============================================================================
`default_nettype none

module clsr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire clsr_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   pop_valid,
   input  wire logic              pop,
   output clsr_pkg::cmd_type      pop_cmd
);

   clsr_pkg::cmd_type           entry_ff [clsr_pkg::QUEUE_DEPTH];
   logic [clsr_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [clsr_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [clsr_pkg::QCNT_W-1:0] count_ff;
   logic [clsr_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [clsr_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [clsr_pkg::QCNT_W-1:0] count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full      = count_ff == clsr_pkg::QCNT_W'(clsr_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == clsr_pkg::QPTR_W'(clsr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + clsr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == clsr_pkg::QPTR_W'(clsr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + clsr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + clsr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - clsr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/clsr_back.sv]
// ============================================================================
// Command back end
// Owns the shadow buffer, the dirty flag and the refresh position, executes
// queued commands and holds the response register.
// ============================================================================
`default_nettype none

module clsr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire clsr_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output clsr_pkg::rsp_type      rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_TICK = 4'b1000
   } state_type;

   state_type                   state_ff;
   state_type                   state_in;
   logic [clsr_pkg::ROW_W-1:0]  cur_row_ff;
   logic [clsr_pkg::ROW_W-1:0]  cur_row_in;
   logic [clsr_pkg::COL_W-1:0]  cur_col_ff;
   logic [clsr_pkg::COL_W-1:0]  cur_col_in;
   logic [7:0]                  value_ff;
   logic [7:0]                  value_in;
   logic                        multi_ff;
   logic                        multi_in;
   logic                        all_rows_ff;
   logic                        all_rows_in;
   logic                        dirty_ff;
   logic                        dirty_in;
   logic                        pass_active_ff;
   logic                        pass_active_in;
   logic [clsr_pkg::ROW_W-1:0]  pass_row_ff;
   logic [clsr_pkg::ROW_W-1:0]  pass_row_in;
   logic [clsr_pkg::SLOT_W-1:0] pass_slot_ff;
   logic [clsr_pkg::SLOT_W-1:0] pass_slot_in;
   logic                        backlight_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   clsr_pkg::rsp_type           rsp_ff;

   // Shadow buffer with per-entry valid bits; an entry never written reads zero.
   logic [7:0]                  mem [clsr_pkg::DEPTH];
   logic                        entry_valid_ff [clsr_pkg::DEPTH];
   logic [7:0]                  rd_a_ff;
   logic [7:0]                  rd_b_ff;
   logic                        rd_a_vld_ff;
   logic                        rd_b_vld_ff;
   logic [clsr_pkg::ADDR_W-1:0] addr_a;
   logic [clsr_pkg::ADDR_W-1:0] addr_b;
   logic [clsr_pkg::ADDR_W-1:0] cur_addr;
   logic [7:0]                  rd_a_byte;
   logic [7:0]                  rd_b_byte;
   logic                        mem_we;

   // Refresh step values.
   logic                        slot_is_cmd;
   logic [7:0]                  lcd_byte;
   logic                        next_ok;
   logic                        last;
   logic                        load_rsp;

   assign cur_addr  = clsr_pkg::char_addr(cur_row_ff, cur_col_ff);
   assign rd_a_byte = rd_a_vld_ff ? rd_a_ff : 8'h00;
   assign rd_b_byte = rd_b_vld_ff ? rd_b_ff : 8'h00;

   // Read addresses: port A serves the byte update and the current refresh
   // character, port B looks ahead at the next refresh character.
   always_comb begin
      if (state_ff == ST_READ) begin
         addr_a = cur_addr;
      end else if (pass_slot_ff == '0) begin
         addr_a = '0;
      end else begin
         addr_a = clsr_pkg::char_addr(pass_row_ff,
                                      clsr_pkg::COL_W'(pass_slot_ff - clsr_pkg::SLOT_W'(1)));
      end
      if (pass_slot_ff < clsr_pkg::SLOT_W'(clsr_pkg::COLUMNS)) begin
         addr_b = clsr_pkg::char_addr(pass_row_ff, clsr_pkg::COL_W'(pass_slot_ff));
      end else begin
         addr_b = '0;
      end
   end

   // Refresh step: the current byte and whether the pass goes on.
   assign slot_is_cmd = pass_slot_ff == '0;
   assign lcd_byte    = slot_is_cmd ?
                        (clsr_pkg::CURSOR_CMD | clsr_pkg::row_offset(pass_row_ff)) : rd_a_byte;
   assign next_ok     = (pass_slot_ff < clsr_pkg::SLOT_W'(clsr_pkg::COLUMNS)) &&
                        (rd_b_byte != 8'h00);
   assign last        = !next_ok && (pass_row_ff == clsr_pkg::ROW_W'(clsr_pkg::ROWS - 1));
   assign load_rsp    = state_ff == ST_TICK;

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      value_in       = value_ff;
      multi_in       = multi_ff;
      all_rows_in    = all_rows_ff;
      dirty_in       = dirty_ff;
      pass_active_in = pass_active_ff;
      pass_row_in    = pass_row_ff;
      pass_slot_in   = pass_slot_ff;
      cmd_pop        = 1'b0;
      mem_we         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  clsr_pkg::OP_WRITE, clsr_pkg::OP_PAD, clsr_pkg::OP_CLEAR: begin
                     cmd_pop     = 1'b1;
                     cur_row_in  = (cmd.op == clsr_pkg::OP_CLEAR) ? '0 : cmd.row;
                     cur_col_in  = (cmd.op == clsr_pkg::OP_CLEAR) ? '0 : cmd.col;
                     value_in    = cmd.value;
                     multi_in    = cmd.op != clsr_pkg::OP_WRITE;
                     all_rows_in = cmd.op == clsr_pkg::OP_CLEAR;
                     // Padding from past the last column changes nothing.
                     if (cmd.op == clsr_pkg::OP_PAD &&
                         cmd.col >= clsr_pkg::COL_W'(clsr_pkg::COLUMNS)) begin
                        state_in = ST_IDLE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  clsr_pkg::OP_FAIL: begin
                     cmd_pop        = 1'b1;
                     pass_active_in = 1'b0;
                     pass_row_in    = '0;
                     pass_slot_in   = '0;
                     dirty_in       = 1'b1;
                  end
                  clsr_pkg::OP_TICK: begin
                     // A refresh step waits for a free response register.
                     if (!rsp_valid_ff) begin
                        cmd_pop = 1'b1;
                        if (pass_active_ff || dirty_ff) begin
                           if (!pass_active_ff) begin
                              dirty_in       = 1'b0;
                              pass_active_in = 1'b1;
                           end
                           state_in = ST_TICK;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Write only a changed byte, and mark the buffer dirty.
            if (rd_a_byte != value_ff) begin
               mem_we   = 1'b1;
               dirty_in = 1'b1;
            end
            if (!multi_ff) begin
               state_in = ST_IDLE;
            end else if (cur_col_ff == clsr_pkg::COL_W'(clsr_pkg::COLUMNS - 1)) begin
               if (all_rows_ff && cur_row_ff != clsr_pkg::ROW_W'(clsr_pkg::ROWS - 1)) begin
                  cur_row_in = cur_row_ff + clsr_pkg::ROW_W'(1);
                  cur_col_in = '0;
                  state_in   = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cur_col_in = cur_col_ff + clsr_pkg::COL_W'(1);
               state_in   = ST_READ;
            end
         end
         ST_TICK: begin
            state_in = ST_IDLE;
            if (next_ok) begin
               pass_slot_in = pass_slot_ff + clsr_pkg::SLOT_W'(1);
            end else if (last) begin
               pass_active_in = 1'b0;
               pass_row_in    = '0;
               pass_slot_in   = '0;
            end else begin
               pass_row_in  = pass_row_ff + clsr_pkg::ROW_W'(1);
               pass_slot_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: loaded only while empty, held while stalled.
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         dirty_ff       <= 1'b0;
         pass_active_ff <= 1'b0;
         pass_row_ff    <= '0;
         pass_slot_ff   <= '0;
         backlight_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         dirty_ff       <= dirty_in;
         pass_active_ff <= pass_active_in;
         pass_row_ff    <= pass_row_in;
         pass_slot_ff   <= pass_slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            backlight_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_row_ff  <= cur_row_in;
      cur_col_ff  <= cur_col_in;
      value_ff    <= value_in;
      multi_ff    <= multi_in;
      all_rows_ff <= all_rows_in;
      if (load_rsp) begin
         rsp_ff <= clsr_pkg::make_frame(lcd_byte, !slot_is_cmd, backlight_ff, last);
      end
   end

   // Buffer valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < clsr_pkg::DEPTH; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (mem_we) begin
         entry_valid_ff[cur_addr] <= 1'b1;
      end
   end

   // Buffer storage with two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_addr] <= value_ff;
      end
      rd_a_ff     <= mem[addr_a];
      rd_b_ff     <= mem[addr_b];
      rd_a_vld_ff <= entry_valid_ff[addr_a];
      rd_b_vld_ff <= entry_valid_ff[addr_b];
   end

endmodule

`default_nettype wire

[rtl/char_lcd_shadow_refresh_unit.sv]
// Path: a frame's tick passes the command queue, the ST_TICK state and the response
// register once it is free. Requests enter a two-entry command queue at one per
// cycle while it has room; the back end takes a write through ST_READ and ST_CMP, a
// frame through ST_TICK, and a line end or clear through both states per byte.
// Reset: synchronous; the buffer reads as zero through per-entry valid bits
// right after reset, with no clearing pass, and the backlight bit resets to 1.
// ============================================================================
// Character LCD shadow refresh unit
// Shadow character buffer with a byte-serial refresh through a 4-bit expander.
// ============================================================================
`default_nettype none

module char_lcd_shadow_refresh_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire clsr_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output clsr_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data
);

   logic              push;
   logic              queue_full;
   clsr_pkg::cmd_type push_cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   clsr_pkg::cmd_type cmd;

   // Front end: request classification.
   clsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Command queue.
   clsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop_valid (cmd_valid),
      .pop       (cmd_pop),
      .pop_cmd   (cmd)
   );

   // Back end: buffer, refresh sequencer and response register.
   clsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[rtl/clsr_checker.sv]
// ============================================================================
// Port checker for the character LCD shadow refresh unit
// Watches the response port over time and is bound to the top level.
// ============================================================================
`default_nettype none

`include "char_lcd_shadow_refresh_unit_assert.svh"

module clsr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire clsr_pkg::rsp_type rsp_payload
);

   // No response may be pending right after reset.
   `CLSR_ASSERT_NXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid, "response valid after reset")

   // A stalled response stays valid and unchanged.
   `CLSR_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
   `CLSR_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "stalled response changed")

   // A cursor command has its top bit set; a character byte is never zero.
   `CLSR_ASSERT_IMP(a_byte_kind, clock, reset, rsp_valid, (rsp_payload.is_data ? (rsp_payload.frame_byte_0[7:4] != 4'h0 || rsp_payload.frame_byte_2[7:4] != 4'h0) : rsp_payload.frame_byte_0[7]), "bad frame byte for its kind")

endmodule

bind char_lcd_shadow_refresh_unit clsr_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
